[src/glh_pkg.sv]
// Package for the gray-level histogram block.
// Holds the shared widths, opcodes and the memory write request type.
// No dependencies.
`default_nettype none

package glh_pkg;

    localparam int COUNT_WIDTH = 24;
    localparam int BIN_BITS    = 8;
    localparam int NUM_BINS    = 256;

    localparam logic OP_COUNT = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [BIN_BITS-1:0]    bin_t;

    typedef struct packed {
        logic   en;
        bin_t   addr;
        count_t data;
    } wr_req_t;

endpackage

`default_nettype wire

[src/glh_bin_ram.sv]
// Bin counter memory: one synchronous read port and one write port.
// Per-entry valid bits make every bin read as zero after reset.
// Depends on glh_pkg.
`default_nettype none

module glh_bin_ram
    import glh_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    rd_en,
    input  wire bin_t    rd_addr,
    output count_t       rd_data,
    input  wire wr_req_t wr_req
);

    count_t              mem [NUM_BINS];
    logic [NUM_BINS-1:0] valid_reg;
    count_t              rd_data_reg;
    logic                rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_req.en)
        begin
            mem[wr_req.addr] <= wr_req.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_req.en)
            begin
                valid_reg[wr_req.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

[src/glh_update.sv]
// Read-modify-write stage: takes the bin read back from memory, forwards the
// last write for the same bin, increments or clears, and registers results.
// Depends on glh_pkg.
`default_nettype none

module glh_update
    import glh_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  accept,
    input  wire logic  opcode,
    input  wire bin_t  addr,
    input  wire count_t rd_data,
    output wr_req_t    wr_req,
    output logic       done,
    output count_t     bin_count
);

    logic    s1_valid_reg;
    logic    s1_op_reg;
    bin_t    s1_addr_reg;
    logic    wb_valid_reg;
    bin_t    wb_addr_reg;
    count_t  wb_data_reg;
    logic    done_reg;
    count_t  bin_count_reg;
    count_t  old_count;
    count_t  new_count;

    always_comb
    begin
        if (wb_valid_reg && (wb_addr_reg == s1_addr_reg))
        begin
            old_count = wb_data_reg;
        end
        else
        begin
            old_count = rd_data;
        end

        if (s1_op_reg == OP_READ)
        begin
            new_count = '0;
        end
        else if (old_count == '1)
        begin
            new_count = old_count;
        end
        else
        begin
            new_count = old_count + count_t'(1);
        end
    end

    assign wr_req.en   = s1_valid_reg;
    assign wr_req.addr = s1_addr_reg;
    assign wr_req.data = new_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            wb_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            wb_valid_reg <= s1_valid_reg;
            done_reg     <= s1_valid_reg && (s1_op_reg == OP_READ);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg   <= opcode;
            s1_addr_reg <= addr;
        end
        wb_addr_reg   <= s1_addr_reg;
        wb_data_reg   <= new_count;
        bin_count_reg <= old_count;
    end

    assign done      = done_reg;
    assign bin_count = bin_count_reg;

endmodule

`default_nettype wire

[src/gray_level_histogram.sv]
// Top level of the 256-bin gray-level histogram.
// Instantiates glh_bin_ram and glh_update; depends on glh_pkg.
//
// Usage: a request is accepted at a rising edge with start high and busy low.
// With opcode 0 the request adds one to the bin of pixel_value; the counter
// saturates at its maximum and no result is produced. With opcode 1 the
// request returns the count of bin_index on bin_count and clears that bin.
// The result is on bin_count with done high for exactly one cycle; both are
// registered from the request held in the stage-1 registers of glh_update;
// the receiver cannot stall it.
// Throughput is one request per clock: busy stays low. The bin memory is read
// at the accepting edge and the updated bin is written back at the next edge;
// a request that follows one for the same bin takes the written value by
// forwarding.
// Reset clears per-bin valid bits, so every bin reads as zero at once and no
// clearing pass is needed.
`default_nettype none

module gray_level_histogram
    import glh_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   start,
    output logic        busy,
    input  wire logic   opcode,
    input  wire bin_t   pixel_value,
    input  wire bin_t   bin_index,
    output logic        done,
    output count_t      bin_count
);

    logic    accept;
    bin_t    addr;
    count_t  rd_data;
    wr_req_t wr_req;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign addr   = (opcode == OP_READ) ? bin_index : pixel_value;

    glh_bin_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (addr),
        .rd_data (rd_data),
        .wr_req  (wr_req)
    );

    glh_update u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .opcode    (opcode),
        .addr      (addr),
        .rd_data   (rd_data),
        .wr_req    (wr_req),
        .done      (done),
        .bin_count (bin_count)
    );

endmodule

`default_nettype wire
